@@ design/nrda_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nrda_pkg: shared types and constants of the nested range duration core
// Transaction structs, operation codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package nrda_pkg;

  localparam int TIME_W         = 48;
  localparam int COUNT_W        = 24;
  localparam int ID_W           = 8;
  localparam int OP_W           = 2;
  localparam int DROP_W         = 6;
  localparam int SEVERITY_SHIFT = 2;
  localparam int ALU_W          = TIME_W + SEVERITY_SHIFT;

  localparam int TYPE_COUNT_DEF  = 256;
  localparam int STACK_DEPTH_DEF = 32;

  localparam logic [OP_W-1:0] OP_START = 2'd0;
  localparam logic [OP_W-1:0] OP_END   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   type_id;
    logic [TIME_W-1:0] time_ns;
  } item_t;

  typedef struct packed {
    logic               matched;
    logic [DROP_W-1:0]  dropped_opens;
    logic               overflow;
    logic [TIME_W-1:0]  total_ns;
    logic [COUNT_W-1:0] range_count;
    logic               reported;
    logic               severity;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]   type_id;
    logic [TIME_W-1:0] time_ns;
  } open_entry_t;

  typedef struct packed {
    logic [TIME_W-1:0]  total_ns;
    logic [COUNT_W-1:0] range_count;
  } table_entry_t;

endpackage
`default_nettype wire

@@ design/nested_range_duration_accumulator_core.sv @@
`default_nettype none
// Steps from acceptance to the result: start DECODE, DONE; query DECODE, QREP,
// QSEV, DONE; end DECODE, SCAN (one stack entry scanned per cycle from the top),
// then on a match SUB, ADD, DONE; clear DECODE, CLEAR (one table valid bit cleared
// per cycle), DONE. One item in work at a time; a finished result waits in the output
// register while the next item is taken. Reset (rst, synchronous) empties the stack,
// zeroes the threshold and sweeps the table valid bits; no item is taken meanwhile.
// ----------------------------------------------------------------------------
// nested_range_duration_accumulator_core
// Stack of open ranges and per-id duration table, worked by a small sequencer
// around one shared 50-bit add/subtract unit.
// ----------------------------------------------------------------------------
module nested_range_duration_accumulator_core #(
  parameter int TYPE_COUNT  = nrda_pkg::TYPE_COUNT_DEF,
  parameter int STACK_DEPTH = nrda_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  output      logic                        item_stall,
  input  wire nrda_pkg::item_t             item_data,
  output      logic                        result_valid,
  input  wire logic                        result_stall,
  output      nrda_pkg::result_t           result_data,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [nrda_pkg::TIME_W-1:0] cfg_data
);

  localparam int TA_W  = $clog2(TYPE_COUNT);
  localparam int SA_W  = $clog2(STACK_DEPTH);
  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int TW    = nrda_pkg::TIME_W;
  localparam int CW    = nrda_pkg::COUNT_W;
  localparam int AW    = nrda_pkg::ALU_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_SUB    = 4'd3;
  localparam logic [3:0] S_ADD    = 4'd4;
  localparam logic [3:0] S_QREP   = 4'd5;
  localparam logic [3:0] S_QSEV   = 4'd6;
  localparam logic [3:0] S_CLEAR  = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  logic [3:0]            state;
  nrda_pkg::item_t       item;
  nrda_pkg::result_t     res;
  logic [TW-1:0]         threshold;
  logic [LVL_W-1:0]      level;
  logic [SA_W-1:0]       ptr;
  logic                  issue_live;
  logic                  cmp_valid;
  logic [SA_W-1:0]       cmp_idx;
  logic [SA_W-1:0]       found_idx;
  logic [TW-1:0]         start_time;
  logic [TW-1:0]         elapsed;
  logic                  rep;
  logic                  emit_clear;
  logic [TA_W-1:0]       sweep_idx;

  nrda_pkg::open_entry_t  stk_mem [STACK_DEPTH];
  nrda_pkg::open_entry_t  stk_rd;
  nrda_pkg::table_entry_t tbl_mem [TYPE_COUNT];
  logic                   vld_mem [TYPE_COUNT];
  nrda_pkg::table_entry_t tbl_rd;
  logic                   vld_rd;

  logic                   accept;
  logic                   id_ok;
  logic                   full;
  logic [TA_W-1:0]        tbl_addr;
  logic                   stk_push;
  logic                   tbl_upd;
  logic                   sweep_wr;
  logic                   out_free;

  logic [AW-1:0]          alu_a;
  logic [AW-1:0]          alu_b;
  logic                   alu_sub;
  logic [AW:0]            alu_sum;
  logic                   alu_carry;
  logic [TW-1:0]          base_total;
  logic [CW-1:0]          base_count;
  logic [TW-1:0]          new_total;
  logic [CW-1:0]          new_count;
  logic                   match;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign id_ok      = (32'(item.type_id) < 32'(TYPE_COUNT));
  assign full       = (level == LVL_W'(STACK_DEPTH));
  assign tbl_addr   = TA_W'(item.type_id);
  assign match      = cmp_valid && (stk_rd.type_id == item.type_id);

  assign stk_push = (state == S_DECODE) && (item.operation == nrda_pkg::OP_START) &&
                    id_ok && !full;
  assign tbl_upd  = (state == S_ADD);
  assign sweep_wr = (state == S_CLEAR);

  // Shared adder: subtract for compares and elapsed time, add for the total
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state)
      S_QREP: begin
        alu_a   = AW'(tbl_rd.total_ns);
        alu_b   = AW'(threshold);
        alu_sub = 1'b1;
      end
      S_QSEV: begin
        alu_a   = AW'(tbl_rd.total_ns);
        alu_b   = AW'(threshold) << nrda_pkg::SEVERITY_SHIFT;
        alu_sub = 1'b1;
      end
      S_SUB: begin
        alu_a   = AW'(item.time_ns);
        alu_b   = AW'(start_time);
        alu_sub = 1'b1;
      end
      S_ADD: begin
        alu_a   = AW'(base_total);
        alu_b   = AW'(elapsed);
        alu_sub = 1'b0;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW+1)'(alu_sub);
  assign alu_carry = alu_sum[AW];

  assign base_total = vld_rd ? tbl_rd.total_ns : '0;
  assign base_count = vld_rd ? tbl_rd.range_count : '0;
  // Saturate on carry out of the time field
  assign new_total  = alu_sum[TW] ? {TW{1'b1}} : alu_sum[TW-1:0];
  assign new_count  = (&base_count) ? base_count : base_count + 1'b1;

  // Stack of open ranges
  always_ff @(posedge clk) begin
    if (stk_push) begin
      stk_mem[SA_W'(level)] <= '{type_id: item.type_id, time_ns: item.time_ns};
    end
    stk_rd <= stk_mem[ptr];
  end

  // Per-id table and its valid bits
  always_ff @(posedge clk) begin
    if (tbl_upd) begin
      tbl_mem[tbl_addr] <= '{total_ns: new_total, range_count: new_count};
    end
    if (sweep_wr) begin
      vld_mem[sweep_idx] <= 1'b0;
    end else if (tbl_upd) begin
      vld_mem[tbl_addr] <= 1'b1;
    end
    tbl_rd <= tbl_mem[tbl_addr];
    vld_rd <= vld_mem[tbl_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      level        <= '0;
      sweep_idx    <= '0;
      emit_clear   <= 1'b0;
      issue_live   <= 1'b0;
      cmp_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          res <= '{overflow: (item.operation == nrda_pkg::OP_START) && id_ok && full,
                   default: '0};
          if (item.operation == nrda_pkg::OP_CLEAR) begin
            level      <= '0;
            sweep_idx  <= '0;
            emit_clear <= 1'b1;
            state      <= S_CLEAR;
          end else if (!id_ok) begin
            state <= S_DONE;
          end else begin
            case (item.operation)
              nrda_pkg::OP_START: begin
                if (!full) begin
                  level <= level + 1'b1;
                end
                state <= S_DONE;
              end
              nrda_pkg::OP_END: begin
                if (level == '0) begin
                  state <= S_DONE;
                end else begin
                  ptr        <= SA_W'(level - 1'b1);
                  issue_live <= 1'b1;
                  cmp_valid  <= 1'b0;
                  state      <= S_SCAN;
                end
              end
              default: begin
                state <= S_QREP;
              end
            endcase
          end
        end
        S_SCAN: begin
          // Read one entry per cycle from the top; compare it in the cycle after its read
          cmp_valid <= issue_live;
          cmp_idx   <= ptr;
          if (ptr != '0) begin
            ptr <= ptr - 1'b1;
          end
          if (match) begin
            start_time <= stk_rd.time_ns;
            found_idx  <= cmp_idx;
            issue_live <= 1'b0;
            state      <= S_SUB;
          end else if (cmp_valid && cmp_idx == '0) begin
            issue_live <= 1'b0;
            state      <= S_DONE;
          end else if (ptr == '0) begin
            issue_live <= 1'b0;
          end
        end
        S_SUB: begin
          // Clamp an end earlier than its start to zero
          elapsed <= alu_carry ? alu_sum[TW-1:0] : '0;
          state   <= S_ADD;
        end
        S_ADD: begin
          res.matched       <= 1'b1;
          res.dropped_opens <= nrda_pkg::DROP_W'(32'(level) - 32'(found_idx) - 1);
          level             <= LVL_W'(found_idx);
          state             <= S_DONE;
        end
        S_QREP: begin
          rep   <= alu_carry;
          state <= S_QSEV;
        end
        S_QSEV: begin
          if (vld_rd) begin
            res.total_ns    <= tbl_rd.total_ns;
            res.range_count <= tbl_rd.range_count;
            res.reported    <= rep;
            res.severity    <= rep && alu_carry;
          end
          state <= S_DONE;
        end
        S_CLEAR: begin
          if (sweep_idx == TA_W'(TYPE_COUNT - 1)) begin
            state <= emit_clear ? S_DONE : S_IDLE;
          end else begin
            sweep_idx <= sweep_idx + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            result_data  <= res;
            result_valid <= 1'b1;
            emit_clear   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_DONE))
    else $error("result loaded outside completion state");

  a_match_pops: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |=> (level < $past(level)))
    else $error("matched end did not pop the stack");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> (level == '0))
    else $error("stack not empty during table clear");

  a_scan_below_level: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && cmp_valid) |-> (32'(cmp_idx) < 32'(level)))
    else $error("scan compared an entry above the stack level");
`endif

endmodule
`default_nettype wire
